>>> design/rbl_pkg.sv
// ----------------------------------------------------------------------------
// rbl_pkg: shared types and constants of the rgb 3x3 blur
// widths, config register indexes, kernel weights and the reciprocal
// used for the divide by the kernel total
// ----------------------------------------------------------------------------
package rbl_pkg;

  // pixel layout: red in the top byte, blue in the bottom byte
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = CH_W * NUM_CH;
  localparam int WIN_COLS = 3;

  typedef logic [PIX_W-1:0] rbl_pix_t;

  // one window column: row above, current row, row below
  typedef struct packed {
    rbl_pix_t top;
    rbl_pix_t mid;
    rbl_pix_t bot;
  } rbl_col_t;

  // neighbor masks and end of frame for one result position
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
    logic last;
  } rbl_pos_t;

  typedef enum logic {
    OPC_PIXEL = 1'b0,
    OPC_DRAIN = 1'b1
  } rbl_opcode_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FRAME_W_W  = 12;
  localparam int FRAME_H_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_W_W-1:0] FRAME_W_RESET = 12'd640;
  localparam logic [FRAME_H_W-1:0] FRAME_H_RESET = 16'd480;

  localparam int MAX_WIDTH_DEF = 2048;

  // kernel weights, total 167
  localparam int WGT_W = 5;
  localparam logic [WGT_W-1:0] WEIGHT_CORNER = 5'd17;
  localparam logic [WGT_W-1:0] WEIGHT_EDGE   = 5'd19;
  localparam logic [WGT_W-1:0] WEIGHT_CENTER = 5'd23;

  // weighted sum per channel stays at or below 167 * 255
  localparam int SUM_W = 16;
  localparam logic [SUM_W-1:0] SUM_MAX = 16'd42585;

  // floor(s / 167) = (s * 50232) >> 23, exact for s <= 42585
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP = 16'd50232;
  localparam int PROD_W = SUM_W + RECIP_W;

endpackage

>>> design/rbl_in_if.sv
// ----------------------------------------------------------------------------
// rbl_in_if: input pixel channel
// valid/ready handshake with opcode and the three samples of one pixel
// ----------------------------------------------------------------------------
interface rbl_in_if import rbl_pkg::*; ();

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (
    output valid, opcode, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, red_in, green_in, blue_in,
    output ready
  );

endinterface

>>> design/rbl_out_if.sv
// ----------------------------------------------------------------------------
// rbl_out_if: blurred pixel channel
// valid/ready handshake with the three blurred samples and frame end flag
// ----------------------------------------------------------------------------
interface rbl_out_if import rbl_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_end;

  modport source (
    output valid, red_out, green_out, blue_out, frame_end,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, frame_end,
    output ready
  );

endinterface

>>> design/rbl_line_mem.sv
// ----------------------------------------------------------------------------
// rbl_line_mem: one line of pixel storage
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module rbl_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/rbl_win_cell.sv
// ----------------------------------------------------------------------------
// rbl_win_cell: one column of the 3x3 window
// loads its right neighbor's column, or the new column, on every window shift
// ----------------------------------------------------------------------------
module rbl_win_cell import rbl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     shift_en,
  input  rbl_col_t col_in,
  output rbl_col_t col_out
);

  rbl_col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

>>> design/rgb_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_blur_3x3: streaming 3x3 blur of an rgb frame
// raster pixels in, each pixel blurred per channel by a fixed kernel out
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls, and gives at most one
// result per item: every channel becomes floor((17*corners + 19*edges +
// 23*center) / 167) over the 3x3 neighborhood, neighbors outside the frame
// count as zero, so borders come out darker. The first result of a frame
// appears once frame_width + 2 items of that frame are in; after the frame's
// last pixel send frame_width + 1 drain items (opcode 1) to push out the
// rest. The result for the last pixel carries frame_end, after which a new
// frame starts. Pixels beyond the frame are treated as drain items and a
// drain item inside the frame is a black pixel. Internally an item passes
// four registered stages (line memory read, window, weighted sum, divide);
// each of the two line memories does one read and one write per clock,
// which is what sets the one item per clock rate. Configuration
// (frame_width, frame_height) must only be written while the block is
// idle; widths above MAX_WIDTH are clamped and zero sizes act as one.
// ----------------------------------------------------------------------------
module rgb_blur_3x3 import rbl_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rbl_in_if.sink                in_if,
  rbl_out_if.source             out_if,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  // column counters index the line memories, one more bit holds the width
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int EXTW = (WW > FRAME_W_W) ? WW : FRAME_W_W;

  // configuration registers
  logic [FRAME_W_W-1:0] frame_width_r;
  logic [FRAME_H_W-1:0] frame_height_r;

  // stream position counters
  logic [CW-1:0]        in_column_r,  in_column_nxt;
  logic [FRAME_H_W-1:0] in_row_r,     in_row_nxt;
  logic [CW-1:0]        out_column_r, out_column_nxt;
  logic [FRAME_H_W-1:0] out_row_r,    out_row_nxt;

  logic [WW-1:0]        w_eff;
  logic [FRAME_H_W-1:0] h_eff;

  // accept side decode
  logic     in_fire;
  logic     frame_done;
  logic     emit;
  rbl_pix_t px_in;
  rbl_pos_t pos;
  logic [WW-1:0] col_inc;
  logic [WW-1:0] ocol_inc;

  // handshake chain
  logic out_free, sum_free, win_free, s1_free;
  logic s1_adv, win_adv, sum_adv;

  // stage 1: line memory read in flight
  logic          s1_valid_r;
  rbl_pix_t      s1_px_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_emit_r;
  rbl_pos_t      s1_pos_r;
  logic          byp_r;
  rbl_pix_t      byp_pix_r;
  rbl_pix_t      upper_rd, lower_rd;

  // stage 2: window holds the item's neighborhood
  logic     win_valid_r;
  rbl_pos_t win_pos_r;
  rbl_col_t new_col;
  rbl_col_t cell_in [WIN_COLS];
  rbl_col_t col_q   [WIN_COLS];

  // stage 3: weighted sums
  logic             sum_valid_r;
  logic             sum_end_r;
  logic [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [SUM_W-1:0] sum_r   [NUM_CH];

  // stage 4: output register
  logic              out_valid_r;
  logic              out_end_r;
  logic [PROD_W-1:0] prod    [NUM_CH];
  logic [CH_W-1:0]   quo_r   [NUM_CH];

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_W_RESET;
      frame_height_r <= FRAME_H_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data[FRAME_W_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data[FRAME_H_W-1:0];
        default:          ;
      endcase
    end
  end

  // effective sizes: width clamped to 1..MAX_WIDTH, height 0 acts as 1
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (EXTW'(frame_width_r) > EXTW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff = (frame_height_r == '0) ? FRAME_H_W'(1) : frame_height_r;
  end

  // ---------------------------------------------------------------- handshake
  // each stage moves when the one after it is empty or moving
  always_comb begin
    out_free = !out_valid_r || out_if.ready;
    sum_free = !sum_valid_r || out_free;
    win_free = !win_valid_r || sum_free;
    s1_free  = !s1_valid_r  || win_free;
    s1_adv   = s1_valid_r  && win_free;
    win_adv  = win_valid_r && sum_free;
    sum_adv  = sum_valid_r && out_free;
  end

  assign in_if.ready = s1_free;

  // ---------------------------------------------------------------- positions
  always_comb begin
    in_fire    = in_if.valid && in_if.ready;
    frame_done = in_row_r >= h_eff;
    // a result is due once one line plus one pixel of the frame are in
    emit = (in_row_r >= FRAME_H_W'(2)) ||
           (in_row_r == FRAME_H_W'(1) && in_column_r != '0);
    // drain items and pixels past the frame end enter as black
    if (in_if.opcode == OPC_PIXEL && !frame_done) begin
      px_in = {in_if.red_in, in_if.green_in, in_if.blue_in};
    end else begin
      px_in = '0;
    end

    col_inc   = {1'b0, in_column_r} + WW'(1);
    ocol_inc  = {1'b0, out_column_r} + WW'(1);
    pos.up    = out_row_r != '0;
    pos.down  = ({1'b0, out_row_r} + (FRAME_H_W + 1)'(1)) < {1'b0, h_eff};
    pos.left  = out_column_r != '0;
    pos.right = ocol_inc < w_eff;
    pos.last  = !pos.down && !pos.right;

    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;

    if (in_fire) begin
      if (col_inc >= w_eff) begin
        in_column_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + FRAME_H_W'(1);
        end
      end else begin
        in_column_nxt = col_inc[CW-1:0];
      end

      if (emit) begin
        if (pos.last) begin
          // frame complete: the next item starts a new frame
          in_column_nxt  = '0;
          in_row_nxt     = '0;
          out_column_nxt = '0;
          out_row_nxt    = '0;
        end else if (!pos.right) begin
          out_column_nxt = '0;
          if (out_row_r != '1) begin
            out_row_nxt = out_row_r + FRAME_H_W'(1);
          end
        end else begin
          out_column_nxt = ocol_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
    end else begin
      in_column_r  <= in_column_nxt;
      in_row_r     <= in_row_nxt;
      out_column_r <= out_column_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------- line memories
  // lower line: written with the new pixel as its old value is read
  rbl_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PIX_W)
  ) u_lower_mem (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (in_column_r),
    .wr_data (px_in),
    .rd_en   (in_fire),
    .rd_addr (in_column_r),
    .rd_data (lower_rd)
  );

  // upper line: takes the old lower value one stage later
  rbl_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PIX_W)
  ) u_upper_mem (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (lower_rd),
    .rd_en   (in_fire),
    .rd_addr (in_column_r),
    .rd_data (upper_rd)
  );

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      // one-pixel lines: the upper write of the item ahead lands on the
      // same address in this very cycle, so take its data directly
      byp_r      <= s1_valid_r && (s1_col_r == in_column_r);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= px_in;
      s1_col_r  <= in_column_r;
      s1_emit_r <= emit;
      s1_pos_r  <= pos;
      byp_pix_r <= lower_rd;
    end
  end

  // ---------------------------------------------------------------- window
  always_comb begin
    new_col.top = byp_r ? byp_pix_r : upper_rd;
    new_col.mid = lower_rd;
    new_col.bot = s1_px_r;
    for (int k = 0; k < WIN_COLS; k++) begin
      if (k == WIN_COLS - 1) begin
        cell_in[k] = new_col;
      end else begin
        cell_in[k] = col_q[k+1];
      end
    end
  end

  // cell 0 is the left column, the new column enters at the right end
  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    rbl_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_adv),
      .col_in   (cell_in[k]),
      .col_out  (col_q[k])
    );
  end

  // every item shifts the window, only items that owe a result stay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
    end else if (s1_adv) begin
      win_valid_r <= s1_emit_r;
    end else if (win_adv) begin
      win_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_pos_r <= s1_pos_r;
    end
  end

  // ---------------------------------------------------------------- weighted sum
  function automatic logic [SUM_W-1:0] tap(
    input logic [CH_W-1:0]  v,
    input logic [WGT_W-1:0] wgt,
    input logic             en
  );
    return en ? (SUM_W'(v) * SUM_W'(wgt)) : '0;
  endfunction

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_nxt[ch] =
        tap(col_q[1].mid[CH_W*ch +: CH_W], WEIGHT_CENTER, 1'b1) +
        tap(col_q[1].top[CH_W*ch +: CH_W], WEIGHT_EDGE,   win_pos_r.up) +
        tap(col_q[1].bot[CH_W*ch +: CH_W], WEIGHT_EDGE,   win_pos_r.down) +
        tap(col_q[0].mid[CH_W*ch +: CH_W], WEIGHT_EDGE,   win_pos_r.left) +
        tap(col_q[2].mid[CH_W*ch +: CH_W], WEIGHT_EDGE,   win_pos_r.right) +
        tap(col_q[0].top[CH_W*ch +: CH_W], WEIGHT_CORNER, win_pos_r.up && win_pos_r.left) +
        tap(col_q[2].top[CH_W*ch +: CH_W], WEIGHT_CORNER, win_pos_r.up && win_pos_r.right) +
        tap(col_q[0].bot[CH_W*ch +: CH_W], WEIGHT_CORNER, win_pos_r.down && win_pos_r.left) +
        tap(col_q[2].bot[CH_W*ch +: CH_W], WEIGHT_CORNER, win_pos_r.down && win_pos_r.right);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (win_adv) begin
      sum_valid_r <= 1'b1;
    end else if (sum_adv) begin
      sum_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_adv) begin
      sum_r     <= sum_nxt;
      sum_end_r <= win_pos_r.last;
    end
  end

  // ---------------------------------------------------------------- divide by 167
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(sum_r[ch]) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_adv) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        quo_r[ch] <= prod[ch][RECIP_SHIFT +: CH_W];
      end
      out_end_r <= sum_end_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.red_out   = quo_r[2];
  assign out_if.green_out = quo_r[1];
  assign out_if.blue_out  = quo_r[0];
  assign out_if.frame_end = out_end_r;

  // ---------------------------------------------------------------- assertions
  // the frame's last result restarts every position counter
  a_frame_restart: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && emit && pos.last) |=>
      (in_column_r == '0 && in_row_r == '0 && out_column_r == '0 && out_row_r == '0)
  ) else $error("position counters not cleared after frame end");

  // the reciprocal divide is exact only within the kernel's sum range
  a_sum_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    sum_valid_r |->
      (sum_r[0] <= SUM_MAX && sum_r[1] <= SUM_MAX && sum_r[2] <= SUM_MAX)
  ) else $error("weighted sum out of range");

endmodule
